@@ hdl/bolw_pkg.sv @@
// Package: shared types and constants of the box outline line walker.
`default_nettype none

package bolw_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned MAX_COORD = 4095;
  localparam int unsigned ERR_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [1:0]              corner_idx_t;

  // corners in tracing order
  localparam corner_idx_t CORNER_TOP_LEFT     = 2'd0;
  localparam corner_idx_t CORNER_TOP_RIGHT    = 2'd1;
  localparam corner_idx_t CORNER_BOTTOM_RIGHT = 2'd2;
  localparam corner_idx_t CORNER_BOTTOM_LEFT  = 2'd3;

  typedef enum logic {
    PIX_SET = 1'b0,
    PIX_INV = 1'b1
  } pix_op_e;

  typedef enum logic [1:0] {
    REG_LEFT_X   = 2'd0,
    REG_BOTTOM_Y = 2'd1,
    REG_RIGHT_X  = 2'd2,
    REG_TOP_Y    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    coord_t left_x;
    coord_t bottom_y;
    coord_t right_x;
    coord_t top_y;
  } box_t;

  typedef struct packed {
    coord_t      cur_x;
    coord_t      cur_y;
    err_t        step_error;
    corner_idx_t corner_index;
    logic        corner_marked;
    logic        active;
  } walk_t;

  typedef struct packed {
    coord_t  pix_x;
    coord_t  pix_y;
    pix_op_e pix_op;
    logic    last;
  } pix_cmd_t;

endpackage

`default_nettype wire

@@ hdl/bolw_if.sv @@
// Interfaces: valid/ready channels for restart/tick words and pixel command words.
`default_nettype none

interface bolw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface bolw_out_if;
  logic                      valid;
  logic                      ready;
  logic [bolw_pkg::COORD_W-1:0] pix_x;
  logic [bolw_pkg::COORD_W-1:0] pix_y;
  logic                      pix_op;
  logic                      last;

  modport source (output valid, output pix_x, output pix_y, output pix_op, output last,
                  input ready);
  modport sink   (input valid, input pix_x, input pix_y, input pix_op, input last,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/bolw_step.sv @@
// Step unit: one Bresenham update of the outline walker and its pixel command.
`default_nettype none

module bolw_step (
  input  bolw_pkg::box_t     box_i,
  input  bolw_pkg::walk_t    walk_i,
  output bolw_pkg::walk_t    walk_o,
  output bolw_pkg::pix_cmd_t cmd_o
);
  import bolw_pkg::*;

  coord_t      tx, ty, sx, sy;
  coord_t      dxc, dyc;
  logic signed [ERR_W:0] dx_w, dy_w, e2;
  err_t        err_a;
  coord_t      nx, ny;
  corner_idx_t prev_idx;

  assign prev_idx = walk_i.corner_index - corner_idx_t'(1);

  // target corner and segment start corner
  always_comb begin
    case (walk_i.corner_index)
      CORNER_TOP_LEFT:     begin tx = box_i.left_x;  ty = box_i.top_y;    end
      CORNER_TOP_RIGHT:    begin tx = box_i.right_x; ty = box_i.top_y;    end
      CORNER_BOTTOM_RIGHT: begin tx = box_i.right_x; ty = box_i.bottom_y; end
      default:             begin tx = box_i.left_x;  ty = box_i.bottom_y; end
    endcase
    case (prev_idx)
      CORNER_TOP_LEFT:     begin sx = box_i.left_x;  sy = box_i.top_y;    end
      CORNER_TOP_RIGHT:    begin sx = box_i.right_x; sy = box_i.top_y;    end
      CORNER_BOTTOM_RIGHT: begin sx = box_i.right_x; sy = box_i.bottom_y; end
      default:             begin sx = box_i.left_x;  sy = box_i.bottom_y; end
    endcase
  end

  assign dxc  = (tx > sx) ? (tx - sx) : (sx - tx);
  assign dyc  = (ty > sy) ? (ty - sy) : (sy - ty);
  assign dx_w = signed'({{(ERR_W + 1 - COORD_W){1'b0}}, dxc});
  assign dy_w = signed'({{(ERR_W + 1 - COORD_W){1'b0}}, dyc});
  assign e2   = {walk_i.step_error, 1'b0};

  always_comb begin
    walk_o = walk_i;
    err_a  = walk_i.step_error;
    nx     = walk_i.cur_x;
    ny     = walk_i.cur_y;
    cmd_o.last = 1'b0;

    if (!walk_i.corner_marked) begin
      cmd_o.pix_x  = tx;
      cmd_o.pix_y  = ty;
      cmd_o.pix_op = PIX_SET;
      walk_o.corner_marked = 1'b1;
      walk_o.step_error    = err_t'(dx_w - dy_w);
    end else begin
      cmd_o.pix_x  = walk_i.cur_x;
      cmd_o.pix_y  = walk_i.cur_y;
      cmd_o.pix_op = PIX_INV;
      if (e2 > -dy_w) begin
        err_a = err_a - err_t'(dy_w);
        nx    = (sx < tx) ? walk_i.cur_x + coord_t'(1) : walk_i.cur_x - coord_t'(1);
      end
      if (e2 < dx_w) begin
        err_a = err_a + err_t'(dx_w);
        ny    = (sy < ty) ? walk_i.cur_y + coord_t'(1) : walk_i.cur_y - coord_t'(1);
      end
      walk_o.step_error = err_a;
      walk_o.cur_x      = nx;
      walk_o.cur_y      = ny;
    end

    // reached the target corner
    if (nx == tx && ny == ty) begin
      if (walk_i.corner_index == CORNER_BOTTOM_LEFT) begin
        cmd_o.last    = 1'b1;
        walk_o.active = 1'b0;
      end else begin
        walk_o.corner_index  = walk_i.corner_index + corner_idx_t'(1);
        walk_o.corner_marked = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/box_outline_line_walker_core.sv @@
// Top level: box outline walker with config registers, step unit and result register.
//
// Usage:
//   - Box corners are written through the config port (cfg_we_i, cfg_idx_i,
//     cfg_data_i) while the block is idle; a write ends any outline in progress.
//   - in_i carries one word per item: restart=1 loads the walker at
//     (left_x,bottom_y) and yields nothing; restart=0 is a tick that yields
//     one pixel command on out_o while an outline is in progress.
//   - Each corner gets a set-black command, then one invert command per pixel
//     up to that corner; the final command of the fourth corner's run is flagged
//     last, and later ticks yield nothing until the next restart.
// Timing:
//   - One word per cycle sustained while out_o is not stalled; a command appears
//     on out_o in the cycle after its tick is taken, from the result register fed
//     by the single step unit, which does one Bresenham update per cycle while ticks are taken.
//   - in_i.ready is high whenever the result register is empty or being
//     drained, so a stalled receiver holds the result and stops input after
//     one pending word.
// Reset:
//   - rst_ni clears the box registers to zero, the walker to idle and the
//     result register to empty.
`default_nettype none

module box_outline_line_walker_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [1:0]                cfg_idx_i,
  input  wire [bolw_pkg::COORD_W-1:0] cfg_data_i,
  bolw_in_if.sink                  in_i,
  bolw_out_if.source               out_o
);
  import bolw_pkg::*;

  box_t     box_q;
  walk_t    walk_q, walk_d, walk_step;
  pix_cmd_t cmd_step, res_q;
  logic     res_valid_q;
  logic     in_fire, out_fire, res_load;
  coord_t   cfg_val;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = res_valid_q && out_o.ready;
  // a tick while active produces a word
  assign res_load   = in_fire && !in_i.restart && walk_q.active;

  assign cfg_val = (cfg_data_i > coord_t'(MAX_COORD)) ? coord_t'(MAX_COORD) : cfg_data_i;

  bolw_step u_step (
    .box_i  (box_q),
    .walk_i (walk_q),
    .walk_o (walk_step),
    .cmd_o  (cmd_step)
  );

  always_comb begin
    walk_d = walk_q;
    if (cfg_we_i) begin
      walk_d.active = 1'b0;
    end else if (in_fire) begin
      if (in_i.restart) begin
        walk_d.cur_x         = box_q.left_x;
        walk_d.cur_y         = box_q.bottom_y;
        walk_d.step_error    = '0;
        walk_d.corner_index  = CORNER_TOP_LEFT;
        walk_d.corner_marked = 1'b0;
        walk_d.active        = 1'b1;
      end else if (walk_q.active) begin
        walk_d = walk_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q  <= '0;
      walk_q <= '0;
    end else begin
      walk_q <= walk_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LEFT_X:   box_q.left_x   <= cfg_val;
          REG_BOTTOM_Y: box_q.bottom_y <= cfg_val;
          REG_RIGHT_X:  box_q.right_x  <= cfg_val;
          REG_TOP_Y:    box_q.top_y    <= cfg_val;
          default:      box_q          <= box_q;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (out_fire) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= cmd_step;
    end
  end

  assign out_o.valid  = res_valid_q;
  assign out_o.pix_x  = res_q.pix_x;
  assign out_o.pix_y  = res_q.pix_y;
  assign out_o.pix_op = res_q.pix_op;
  assign out_o.last   = res_q.last;

`ifndef SYNTHESIS
  a_restart_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.restart && !cfg_we_i) |=>
      (walk_q.active && !walk_q.corner_marked && walk_q.corner_index == CORNER_TOP_LEFT))
    else $error("restart did not load the walker");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && !cfg_we_i && cmd_step.last) |=> !walk_q.active)
    else $error("walker still active after last word");

  a_restart_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.restart) |=> (res_valid_q == $past(res_valid_q && !out_o.ready)))
    else $error("restart produced a word");

  a_cfg_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !walk_q.active)
    else $error("config write did not cancel the outline");
`endif

endmodule

`default_nettype wire

@@ test/tb_box_outline_line_walker_core.sv @@
// Testbench: box outline walker checked command by command against a cycle-free predictor.
`timescale 1ns / 100ps

module tb_box_outline_line_walker_core;
  import bolw_pkg::*;

  // Cycles with no accepted word and no register write before the run is called hung.
  // The longest legal quiet stretch is a sender gap or receiver stall from pick_gap plus
  // the drain pause, so this is many times the slowest correct case.
  localparam int STALL_LIMIT  = 2000;
  // Stop the random part once this many counted words have gone in.
  localparam int RANDOM_WORDS = 600;
  // Fixed drain pause: the block answers in the cycle after a tick, a restart yields nothing.
  localparam int DRAIN_CYCLES = 4;

  // Predicts the pixel command stream and holds the commands still owed by the block.
  class outline_tracker;
    coord_t      box_l, box_b, box_r, box_top;
    coord_t      cur_x, cur_y;
    int          step_err;
    corner_idx_t corner;
    bit          marked;
    bit          active;
    pix_cmd_t    owed_cmds[$];
    int          mismatches;

    function new();
      box_l = '0; box_b = '0; box_r = '0; box_top = '0;
      cur_x = '0; cur_y = '0;
      step_err = 0;
      corner = CORNER_TOP_LEFT;
      marked = 1'b0;
      active = 1'b0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 20) $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    function int owed();
      return owed_cmds.size();
    endfunction

    function void corner_xy(corner_idx_t c, output int x, output int y);
      case (c)
        CORNER_TOP_LEFT: begin
          x = box_l; y = box_top;
        end
        CORNER_TOP_RIGHT: begin
          x = box_r; y = box_top;
        end
        CORNER_BOTTOM_RIGHT: begin
          x = box_r; y = box_b;
        end
        default: begin
          x = box_l; y = box_b;
        end
      endcase
    endfunction

    // any register write cancels an outline in progress
    function void write_reg(cfg_reg_e idx, coord_t v);
      case (idx)
        REG_LEFT_X:   box_l = v;
        REG_BOTTOM_Y: box_b = v;
        REG_RIGHT_X:  box_r = v;
        default:      box_top = v;
      endcase
      active = 1'b0;
    endfunction

    function void take_word(bit restart);
      int       tx, ty, sx, sy, dx, dy, e2;
      pix_cmd_t cmd;
      if (restart) begin
        cur_x = box_l;
        cur_y = box_b;
        step_err = 0;
        corner = CORNER_TOP_LEFT;
        marked = 1'b0;
        active = 1'b1;
        return;
      end
      if (!active) return;
      // segment runs from the previous corner to the current one
      corner_xy(corner, tx, ty);
      corner_xy(corner - 2'd1, sx, sy);
      dx = (tx > sx) ? tx - sx : sx - tx;
      dy = (ty > sy) ? ty - sy : sy - ty;
      cmd.last = 1'b0;
      if (!marked) begin
        cmd.pix_x  = coord_t'(tx);
        cmd.pix_y  = coord_t'(ty);
        cmd.pix_op = PIX_SET;
        marked = 1'b1;
        step_err = dx - dy;
      end else begin
        e2 = step_err * 2;
        cmd.pix_x  = cur_x;
        cmd.pix_y  = cur_y;
        cmd.pix_op = PIX_INV;
        if (e2 > -dy) begin
          step_err -= dy;
          cur_x = (sx < tx) ? cur_x + 1'b1 : cur_x - 1'b1;
        end
        if (e2 < dx) begin
          step_err += dx;
          cur_y = (sy < ty) ? cur_y + 1'b1 : cur_y - 1'b1;
        end
      end
      if (cur_x == tx && cur_y == ty) begin
        if (corner == CORNER_BOTTOM_LEFT) begin
          cmd.last = 1'b1;
          active = 1'b0;
        end else begin
          corner = corner + 2'd1;
          marked = 1'b0;
        end
      end
      owed_cmds.insert(owed_cmds.size(), cmd);
    endfunction

    function void check_cmd(pix_cmd_t got);
      pix_cmd_t want;
      if (owed_cmds.size() == 0) begin
        report($sformatf("command (%0d,%0d) op %0d with none owed",
                         got.pix_x, got.pix_y, got.pix_op));
        return;
      end
      want = owed_cmds.pop_front();
      if (got.pix_x !== want.pix_x)
        report($sformatf("pix_x %0d, predicted %0d", got.pix_x, want.pix_x));
      if (got.pix_y !== want.pix_y)
        report($sformatf("pix_y %0d, predicted %0d", got.pix_y, want.pix_y));
      if (got.pix_op !== want.pix_op)
        report($sformatf("pix_op %0d, predicted %0d at (%0d,%0d)",
                         got.pix_op, want.pix_op, want.pix_x, want.pix_y));
      if (got.last !== want.last)
        report($sformatf("last %0d, predicted %0d at (%0d,%0d)",
                         got.last, want.last, want.pix_x, want.pix_y));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [1:0] cfg_idx_i;
  coord_t    cfg_data_i;

  bolw_in_if  in_if ();
  bolw_out_if out_if ();

  box_outline_line_walker_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  outline_tracker tracker;
  pix_cmd_t       seen_cmd;
  int             stall_cycles;
  bit             steady;       // set for stretches with no idling on either side
  coord_t         box_l, box_b, box_r, box_top;  // stimulus-side copy of the box
  int             counted;      // words that count toward the random total

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, a few long; none at all in a steady stretch.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Number of commands in one full outline of the current box: a set-black per corner
  // plus one invert per pixel step; every side is axis aligned so steps = side length.
  function automatic int outline_len();
    int w, h;
    w = (box_l > box_r) ? box_l - box_r : box_r - box_l;
    h = (box_b > box_top) ? box_b - box_top : box_top - box_b;
    return 4 + 2 * w + 2 * h;
  endfunction

  // Anchor coordinate: the edges of the coordinate range come up often.
  function automatic coord_t pick_anchor();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? coord_t'(MAX_COORD) : '0;
    return coord_t'($urandom_range(0, MAX_COORD));
  endfunction

  // Opposite side: usually a few pixels away, in either direction, so boxes are
  // inverted about half the time; sometimes zero width, rarely a few dozen.
  function automatic coord_t pick_partner(coord_t a);
    int r, s, p;
    r = $urandom_range(0, 19);
    if (r == 0) s = 0;
    else if (r == 1) s = $urandom_range(30, 80);
    else s = $urandom_range(1, 12);
    p = $urandom_range(0, 1) ? a + s : a - s;
    if (p > int'(MAX_COORD)) p = a - s;
    if (p < 0) p = a + s;
    return coord_t'(p);
  endfunction

  // One word on the input channel; returns at the edge where it is taken.
  // valid only drops when a gap follows, so back-to-back words keep it high.
  task automatic send_word(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(1'b0);
  endtask

  // Stop sending and wait for every owed command. The first edge lets the monitor
  // book the last word; the pause after covers a restart still settling in the block.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four box registers on consecutive edges, starting at a random one.
  task automatic write_box(coord_t l, coord_t b, coord_t r, coord_t t);
    cfg_reg_e regs [4];
    coord_t   vals [4];
    int       rot, j;
    regs = '{REG_LEFT_X, REG_BOTTOM_Y, REG_RIGHT_X, REG_TOP_Y};
    vals = '{l, b, r, t};
    rot = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      j = (i + rot) % 4;
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[j];
      cfg_data_i <= vals[j];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    box_l = l; box_b = b; box_r = r; box_top = t;
  endtask

  // One random phase: a fresh box, a few ticks while idle (or after the cancel that the
  // write caused), then a restart and the walk. Some phases restart mid-outline, some
  // stop part way so the next write lands on an active walker.
  task automatic random_phase();
    coord_t xa, ya;
    int     len, k, ticks;
    steady = ($urandom_range(0, 5) == 0);
    xa = pick_anchor();
    ya = pick_anchor();
    write_box(xa, ya, pick_partner(xa), pick_partner(ya));
    send_ticks($urandom_range(0, 2));
    send_word(1'b1);
    counted++;
    len = outline_len();
    if ($urandom_range(0, 99) < 15) begin
      k = $urandom_range(0, len - 1);
      send_ticks(k);
      send_word(1'b1);
      counted += k + 1;
    end
    if ($urandom_range(0, 99) < 10) ticks = $urandom_range(1, len - 1);
    else ticks = len + $urandom_range(0, 3);
    send_ticks(ticks);
    counted += (ticks < len) ? ticks : len;
    drain();
  endtask

  // Receiver: ready held for a while, then a random stall.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat (steady ? 50 : $urandom_range(1, 6)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Monitors: register writes, accepted input words and accepted commands all go to the
  // tracker at the edge where they happen. A tick's command shows up in the following cycle
  // at the earliest, so booking the input before checking the output is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_reg(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (in_if.valid && in_if.ready) tracker.take_word(in_if.restart);
      if (out_if.valid && out_if.ready) begin
        seen_cmd.pix_x  = out_if.pix_x;
        seen_cmd.pix_y  = out_if.pix_y;
        seen_cmd.pix_op = pix_op_e'(out_if.pix_op);
        seen_cmd.last   = out_if.last;
        tracker.check_cmd(seen_cmd);
      end
    end
  end

  // Watchdog: cycles in a row with nothing moving on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
    begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    tracker      = new();
    steady       = 1'b0;
    counted      = 0;
    box_l = '0; box_b = '0; box_r = '0; box_top = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LEFT_X;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // tick before any restart: walker is idle, nothing comes out
    send_word(1'b0);
    // reset box is a single point: every side has zero length, so four set-black
    // words at (0,0), the fourth flagged last; the tick after it yields nothing
    send_word(1'b1);
    send_ticks(5);
    drain();
    // inverted box at the top of the range: both axes walk in the negative direction;
    // restart while active drops the partial outline and starts over
    write_box(coord_t'(MAX_COORD), coord_t'(MAX_COORD), coord_t'(MAX_COORD - 2),
              coord_t'(MAX_COORD - 1));
    send_word(1'b1);
    send_ticks(3);
    send_word(1'b1);
    send_ticks(outline_len());
    // register write while active cancels the outline; ticks after it are ignored
    send_word(1'b1);
    send_ticks(2);
    drain();
    write_box('0, '0, 12'd1, 12'd2);
    send_ticks(2);
    drain();

    // --- random ---
    while (counted < RANDOM_WORDS) random_phase();

    // full-range box, first few words only: the set-black at (max,max) and the
    // inverts from (max,0) up toggle every bit of pix_y on the outputs
    steady = 1'b0;
    write_box(coord_t'(MAX_COORD), '0, '0, coord_t'(MAX_COORD));
    send_word(1'b1);
    send_ticks(4);
    drain();

    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
